/* hw/rtl/spk128_pkg.sv */
// Shared types and constants for the Speck128/128 cipher core.
package spk128_pkg;

  localparam int WORD_W        = 64;
  localparam int ROT_X         = 8;
  localparam int ROT_Y         = 3;
  localparam int ROUND_COUNT_D = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    FUNC_ENCRYPT = 1'b0,
    FUNC_DECRYPT = 1'b1
  } func_t;

  typedef struct packed {
    logic  func;
    word_t text_low;
    word_t text_high;
    word_t key_low;
    word_t key_high;
  } cmd_beat_t;

  typedef struct packed {
    word_t out_text_low;
    word_t out_text_high;
    word_t out_key_low;
    word_t out_key_high;
  } rsp_beat_t;

  typedef struct packed {
    logic  func;
    word_t x;
    word_t y;
    word_t a;
    word_t b;
  } round_state_t;

endpackage

/* hw/rtl/speck128_block_cipher_core.sv */
// Top level of the Speck128/128 cipher core: a chain of round cells.
//
//   channel | direction | handshake            | beat
//   cmd     | in        | cmd_valid, cmd_stall | spk128_pkg::cmd_beat_t
//   rsp     | out       | rsp_valid, rsp_stall | spk128_pkg::rsp_beat_t
//
// One block enters per cycle unless cmd_stall is high, and it passes one cell per round.
// Each cell does one data round with the key step beside it (none in the last cell), so the rate is set by
// one 64-bit add or subtract per cell. Reset clears the valid bit of every cell.
// A stalled result holds the last cell; earlier cells keep filling any empty slots,
// and cmd_stall rises only when every cell holds a block.
module speck128_block_cipher_core #(
  parameter int ROUND_COUNT = spk128_pkg::ROUND_COUNT_D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  spk128_pkg::cmd_beat_t cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output spk128_pkg::rsp_beat_t rsp
);

  logic                     valid_c [0:ROUND_COUNT];
  logic                     ready_c [0:ROUND_COUNT];
  spk128_pkg::round_state_t state_c [0:ROUND_COUNT];

  assign state_c[0] = {cmd.func, cmd.text_high, cmd.text_low, cmd.key_high, cmd.key_low};

  assign valid_c[0]           = cmd_valid;
  assign cmd_stall            = !ready_c[0];
  assign ready_c[ROUND_COUNT] = !rsp_stall;

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
    spk128_cell #(
      .ROUND_COUNT(ROUND_COUNT),
      .STAGE      (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (valid_c[g]),
      .up_state  (state_c[g]),
      .up_ready  (ready_c[g]),
      .valid     (valid_c[g+1]),
      .state     (state_c[g+1]),
      .down_ready(ready_c[g+1])
    );
  end

  assign rsp_valid         = valid_c[ROUND_COUNT];
  assign rsp.out_text_low  = state_c[ROUND_COUNT].y;
  assign rsp.out_text_high = state_c[ROUND_COUNT].x;
  assign rsp.out_key_low   = state_c[ROUND_COUNT].b;
  assign rsp.out_key_high  = state_c[ROUND_COUNT].a;

endmodule

/* hw/rtl/spk128_cell.sv */
// One pipeline cell: a single data round and, except in the last cell, one key step.
module spk128_cell #(
  parameter int ROUND_COUNT = spk128_pkg::ROUND_COUNT_D,
  parameter int STAGE       = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  input  spk128_pkg::round_state_t up_state,
  output logic                     up_ready,
  output logic                     valid,
  output spk128_pkg::round_state_t state,
  input  logic                     down_ready
);

  localparam bit KEY_STEP = (STAGE < ROUND_COUNT - 1);
  localparam spk128_pkg::word_t ENC_K = spk128_pkg::word_t'(STAGE);
  localparam spk128_pkg::word_t DEC_K = spk128_pkg::word_t'(ROUND_COUNT - 2 - STAGE);

  function automatic spk128_pkg::word_t ror(input spk128_pkg::word_t v, input int r);
    return (v >> r) | (v << (spk128_pkg::WORD_W - r));
  endfunction

  function automatic spk128_pkg::word_t rol(input spk128_pkg::word_t v, input int r);
    return (v << r) | (v >> (spk128_pkg::WORD_W - r));
  endfunction

  spk128_pkg::round_state_t state_next;
  spk128_pkg::word_t        fx, fy, ix, iy, ka_f, kb_f, ka_i, kb_i;

  always_comb begin
    fx   = (ror(up_state.x, spk128_pkg::ROT_X) + up_state.y) ^ up_state.b;
    fy   = rol(up_state.y, spk128_pkg::ROT_Y) ^ fx;
    iy   = ror(up_state.y ^ up_state.x, spk128_pkg::ROT_Y);
    ix   = rol((up_state.x ^ up_state.b) - iy, spk128_pkg::ROT_X);
    ka_f = (ror(up_state.a, spk128_pkg::ROT_X) + up_state.b) ^ ENC_K;
    kb_f = rol(up_state.b, spk128_pkg::ROT_Y) ^ ka_f;
    kb_i = ror(up_state.b ^ up_state.a, spk128_pkg::ROT_Y);
    ka_i = rol((up_state.a ^ DEC_K) - kb_i, spk128_pkg::ROT_X);

    state_next      = up_state;
    if (up_state.func == spk128_pkg::FUNC_DECRYPT) begin
      state_next.x = ix;
      state_next.y = iy;
      if (KEY_STEP) begin
        state_next.a = ka_i;
        state_next.b = kb_i;
      end
    end else begin
      state_next.x = fx;
      state_next.y = fy;
      if (KEY_STEP) begin
        state_next.a = ka_f;
        state_next.b = kb_f;
      end
    end
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/spk128_checker.sv */
// Port checks for the cipher core, bound to its top level.
module spk128_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_stall,
  input spk128_pkg::cmd_beat_t cmd,
  input logic                  rsp_valid,
  input logic                  rsp_stall,
  input spk128_pkg::rsp_beat_t rsp
);

  // A held result keeps its beat until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Nothing comes out in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result present right after reset");

  // Input back-pressure only when the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled while output is free");

  // Whenever no result is offered, a new block is never stalled.
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !cmd_stall)
    else $error("input stalled with empty output");

  // A stalled input beat stays offered and unchanged.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
    else $error("stalled input beat changed");

endmodule

bind speck128_block_cipher_core spk128_checker u_spk128_checker (.*);

/* sim/speck128_block_cipher_core_tb.sv */
// Self-checking testbench for the Speck128/128 cipher core with a built-in cipher model.
module speck128_block_cipher_core_tb;
  import spk128_pkg::*;

  localparam int ROUNDS      = ROUND_COUNT_D;
  localparam int CLK_HALF    = 6;
  localparam int DRAIN_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_beat_t cmd;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_beat_t rsp;

  rsp_beat_t pending_cipher_results[$];
  int        error_count = 0;
  bit        src_idle_en = 1'b0;
  bit        sink_idle_en = 1'b0;
  int        hold_cycles = 0;

  speck128_block_cipher_core #(
    .ROUND_COUNT(ROUNDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #(2 * CLK_HALF * 300000);
    $display("== FAIL ==");
    $finish;
  end

  function automatic void enc_round(inout word_t x, inout word_t y, input word_t k);
    x = {x[ROT_X-1:0], x[WORD_W-1:ROT_X]};
    x = x + y;
    x = x ^ k;
    y = {y[WORD_W-1-ROT_Y:0], y[WORD_W-1:WORD_W-ROT_Y]};
    y = y ^ x;
  endfunction

  function automatic void dec_round(inout word_t x, inout word_t y, input word_t k);
    y = y ^ x;
    y = {y[ROT_Y-1:0], y[WORD_W-1:ROT_Y]};
    x = x ^ k;
    x = x - y;
    x = {x[WORD_W-1-ROT_X:0], x[WORD_W-1:WORD_W-ROT_X]};
  endfunction

  function automatic rsp_beat_t speck_crypt_block(cmd_beat_t c);
    word_t     x;
    word_t     y;
    word_t     a;
    word_t     b;
    rsp_beat_t r;
    y = c.text_low;
    x = c.text_high;
    b = c.key_low;
    a = c.key_high;
    if (c.func == FUNC_ENCRYPT) begin
      enc_round(x, y, b);
      for (int n = 0; n < ROUNDS - 1; n++) begin
        enc_round(a, b, word_t'(n));
        enc_round(x, y, b);
      end
    end else begin
      for (int n = ROUNDS - 2; n >= 0; n--) begin
        dec_round(x, y, b);
        dec_round(a, b, word_t'(n));
      end
      dec_round(x, y, b);
    end
    r.out_text_low  = y;
    r.out_text_high = x;
    r.out_key_low   = b;
    r.out_key_high  = a;
    return r;
  endfunction

  function automatic cmd_beat_t make_beat(func_t f, word_t tl, word_t th, word_t kl, word_t kh);
    cmd_beat_t c;
    c.func      = f;
    c.text_low  = tl;
    c.text_high = th;
    c.key_low   = kl;
    c.key_high  = kh;
    return c;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w = word_t'(1) << $urandom_range(0, WORD_W - 1);
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return w;
      end
      3: begin
        return ~w;
      end
      default: begin
        return {$urandom, $urandom};
      end
    endcase
  endfunction

  function automatic cmd_beat_t random_beat();
    func_t f;
    f = $urandom_range(0, 1) ? FUNC_DECRYPT : FUNC_ENCRYPT;
    return make_beat(f, rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  function automatic cmd_beat_t inverse_of(cmd_beat_t c);
    rsp_beat_t r;
    r = speck_crypt_block(c);
    return make_beat(c.func == FUNC_ENCRYPT ? FUNC_DECRYPT : FUNC_ENCRYPT,
                     r.out_text_low, r.out_text_high, r.out_key_low, r.out_key_high);
  endfunction

  task automatic send_block(cmd_beat_t beat);
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      cmd_valid = 1'b0;
      cmd = random_beat();
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    cmd = beat;
    cmd_valid = 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_cipher_results = {pending_cipher_results, speck_crypt_block(beat)};
  endtask

  task automatic rest_sender();
    @(negedge clk);
    cmd_valid = 1'b0;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    while (pending_cipher_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_cipher_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time,
               pending_cipher_results.size());
    end
  endtask

  task automatic compare_word(string field, word_t want, word_t got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch expected %h actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    rsp_beat_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_cipher_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat expected none actual %h", $time, rsp);
      end else begin
        want = pending_cipher_results.pop_front();
        compare_word("out_text_low", want.out_text_low, rsp.out_text_low);
        compare_word("out_text_high", want.out_text_high, rsp.out_text_high);
        compare_word("out_key_low", want.out_key_low, rsp.out_key_low);
        compare_word("out_key_high", want.out_key_high, rsp.out_key_high);
      end
    end
  end

  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        rsp_stall = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        rsp_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        rsp_stall = 1'b0;
      end
    end
  end

  task automatic test_directed();
    cmd_beat_t vec;
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    vec = make_beat(FUNC_ENCRYPT, 64'h7469206564616d20, 64'h6c61766975716520,
                    64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_block(vec);
    send_block(inverse_of(vec));
    send_block(make_beat(FUNC_ENCRYPT, '0, '0, '0, '0));
    send_block(make_beat(FUNC_DECRYPT, '0, '0, '0, '0));
    send_block(make_beat(FUNC_ENCRYPT, '1, '1, '1, '1));
    send_block(make_beat(FUNC_DECRYPT, '1, '1, '1, '1));
    send_block(make_beat(FUNC_ENCRYPT, '1, '0, '0, '0));
    send_block(make_beat(FUNC_ENCRYPT, '0, '1, '0, '0));
    send_block(make_beat(FUNC_ENCRYPT, '0, '0, '1, '0));
    send_block(make_beat(FUNC_ENCRYPT, '0, '0, '0, '1));
    send_block(make_beat(FUNC_DECRYPT, '1, '0, '0, '0));
    send_block(make_beat(FUNC_DECRYPT, '0, '1, '0, '0));
    send_block(make_beat(FUNC_DECRYPT, '0, '0, '1, '0));
    send_block(make_beat(FUNC_DECRYPT, '0, '0, '0, '1));
    send_block(make_beat(FUNC_ENCRYPT, 64'h1, 64'h8000000000000000,
                         64'h5555555555555555, 64'haaaaaaaaaaaaaaaa));
    send_block(make_beat(FUNC_DECRYPT, 64'h8000000000000000, 64'h1,
                         64'haaaaaaaaaaaaaaaa, 64'h5555555555555555));
    vec = make_beat(FUNC_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210,
                    64'hffffffffffffffff, 64'h0);
    send_block(vec);
    send_block(inverse_of(vec));
    rest_sender();
  endtask

  task automatic test_random_mix();
    cmd_beat_t beat;
    for (int seg = 0; seg < 8; seg++) begin
      src_idle_en = $urandom_range(0, 1);
      sink_idle_en = $urandom_range(0, 1);
      for (int i = 0; i < 50; i++) begin
        beat = random_beat();
        send_block(beat);
        if ($urandom_range(0, 4) == 0) send_block(inverse_of(beat));
      end
    end
  endtask

  task automatic test_fill_and_stall();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    hold_cycles = 4 * ROUNDS;
    repeat (2 * ROUNDS) send_block(random_beat());
  endtask

  task automatic test_pause_drain();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    repeat (20) send_block(random_beat());
    rest_sender();
    wait_drained();
    repeat (ROUNDS + 4) @(posedge clk);
    repeat (20) send_block(random_beat());
  endtask

  task automatic test_key_chain();
    cmd_beat_t chain[$];
    cmd_beat_t beat;
    rsp_beat_t r;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    beat = make_beat(FUNC_ENCRYPT, rand_word(), rand_word(), rand_word(), rand_word());
    repeat (40) begin
      send_block(beat);
      chain = {chain, beat};
      r = speck_crypt_block(beat);
      beat = make_beat(FUNC_ENCRYPT, rand_word(), rand_word(), r.out_key_low, r.out_key_high);
    end
    while (chain.size() != 0) send_block(inverse_of(chain.pop_back()));
  endtask

  task automatic test_full_rate();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (300) send_block(random_beat());
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_mix();
    test_fill_and_stall();
    test_pause_drain();
    test_key_chain();
    test_full_rate();
    rest_sender();
    wait_drained();
    repeat (ROUNDS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
